// ===== hw/rtl/twtc_pkg.sv =====
package twtc_pkg;

   localparam int unsigned LEVEL_BITS  = 8;
   localparam int unsigned LCOUNT_BITS = 5;
   localparam int unsigned RSP_BITS    = 31;

   localparam logic [LCOUNT_BITS-1:0] LEVEL_RESET = 5'd16;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_COUNT = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_MISSING = 2'd1;
   localparam logic [1:0] STATUS_RANGE   = 2'd2;
   localparam logic [1:0] STATUS_SAT     = 2'd3;

   localparam logic [1:0] REG_X_LEVELS = 2'd0;
   localparam logic [1:0] REG_Y_LEVELS = 2'd1;
   localparam logic [1:0] REG_Z_LEVELS = 2'd2;

   typedef enum logic [2:0] {
      ST_SWEEP  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_UPDATE = 3'b100
   } twtc_state_type;

   // decoded request word
   typedef struct packed {
      logic       clear;
      logic       count;
      logic       hit;
      logic [1:0] status;
   } twtc_dec_type;

   function automatic logic [LCOUNT_BITS-1:0] clamp_levels(
      logic [LCOUNT_BITS-1:0] v, int unsigned top);
      logic [LCOUNT_BITS-1:0] r;
      r = v;
      if (v == '0) begin
         r = LCOUNT_BITS'(1);
      end else if (32'(v) > top) begin
         r = LCOUNT_BITS'(top);
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/twtc_ram.sv =====
module twtc_ram #(
   parameter int unsigned DEPTH     = 16,
   parameter int unsigned WIDTH     = 31,
   parameter int unsigned ADDR_BITS = 4
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/twtc_decode.sv =====
module twtc_decode #(
   parameter int unsigned MAX_X_LEVELS = 16,
   parameter int unsigned MAX_Y_LEVELS = 16,
   parameter int unsigned Z_AW         = 4,
   parameter int unsigned ROW_AW       = 8,
   parameter int unsigned COL_AW       = 8,
   parameter int unsigned CELL_AW      = 12
) (
   input  logic [1:0]                        op,
   input  logic [twtc_pkg::LEVEL_BITS-1:0]   x_level,
   input  logic [twtc_pkg::LEVEL_BITS-1:0]   y_level,
   input  logic [twtc_pkg::LEVEL_BITS-1:0]   z_level,
   input  logic                              any_missing,
   input  logic [twtc_pkg::LCOUNT_BITS-1:0]  x_count,
   input  logic [twtc_pkg::LCOUNT_BITS-1:0]  y_count,
   input  logic [twtc_pkg::LCOUNT_BITS-1:0]  z_count,
   output twtc_pkg::twtc_dec_type            dec,
   output logic [CELL_AW-1:0]                cell_addr,
   output logic [ROW_AW-1:0]                 row_addr,
   output logic [COL_AW-1:0]                 col_addr,
   output logic [Z_AW-1:0]                   slice_addr
);
   import twtc_pkg::*;

   logic [LEVEL_BITS-1:0] xi;
   logic [LEVEL_BITS-1:0] yi;
   logic [LEVEL_BITS-1:0] zi;
   logic                  in_range;
   logic                  skip;

   assign xi = x_level - LEVEL_BITS'(1);
   assign yi = y_level - LEVEL_BITS'(1);
   assign zi = z_level - LEVEL_BITS'(1);

   assign in_range = (x_level != '0) && (x_level <= LEVEL_BITS'(x_count)) &&
                     (y_level != '0) && (y_level <= LEVEL_BITS'(y_count)) &&
                     (z_level != '0) && (z_level <= LEVEL_BITS'(z_count));

   // missing flags only matter on count, and win over range
   assign skip = (op == OP_COUNT) && any_missing;

   always_comb begin
      dec.clear  = (op == OP_CLEAR);
      dec.count  = (op == OP_COUNT);
      dec.hit    = !dec.clear && !skip && in_range;
      dec.status = STATUS_DONE;
      if (!dec.clear) begin
         if (skip) begin
            dec.status = STATUS_MISSING;
         end else if (!in_range) begin
            dec.status = STATUS_RANGE;
         end
      end
   end

   assign row_addr   = ROW_AW'(32'(zi) * MAX_X_LEVELS + 32'(xi));
   assign col_addr   = COL_AW'(32'(zi) * MAX_Y_LEVELS + 32'(yi));
   assign cell_addr  = CELL_AW'(32'(row_addr) * MAX_Y_LEVELS + 32'(yi));
   assign slice_addr = Z_AW'(zi);

endmodule

// ===== hw/rtl/three_way_table_counter_unit.sv =====
// Three-way contingency table counter.
// Input channel: an op word (clear, count, read) with three 1-based levels and
// three missing flags is taken at a clock edge where start is high and busy low.
// Result channel: one word per input, held on the rsp_ ports for one cycle and
// marked by rsp_strobe; the receiver cannot stall and must take it then.
// Config: csr_wr_en writes csr_wdata into level-count register csr_index
// (0 row, 1 column, 2 slice); values clamp to 1..MAX. Write only while idle.
// Count and read: busy in the update state after the accepting edge (memory
// read at that edge, update and write back in that state); the result
// strobes in the cycle after it, when the next word may already be taken.
// Clear: a sweep over the MAX_Z*MAX_X*MAX_Y joint-cell addresses (4096 at
// the defaults) zeroes every store; its result strobes when the sweep ends.
// Reset runs the same sweep without a result; busy stays high until it ends.
// Counters are COUNT_BITS wide and saturate; outputs show their low 31 bits.
module three_way_table_counter_unit #(
   parameter int unsigned MAX_X_LEVELS = 16,
   parameter int unsigned MAX_Y_LEVELS = 16,
   parameter int unsigned MAX_Z_LEVELS = 16,
   parameter int unsigned COUNT_BITS   = 31
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_op,
   input  logic [twtc_pkg::LEVEL_BITS-1:0]   req_x_level,
   input  logic [twtc_pkg::LEVEL_BITS-1:0]   req_y_level,
   input  logic [twtc_pkg::LEVEL_BITS-1:0]   req_z_level,
   input  logic                              req_x_missing,
   input  logic                              req_y_missing,
   input  logic                              req_z_missing,
   output logic                              rsp_strobe,
   output logic [1:0]                        rsp_status,
   output logic [twtc_pkg::RSP_BITS-1:0]     rsp_joint_count,
   output logic [twtc_pkg::RSP_BITS-1:0]     rsp_row_margin,
   output logic [twtc_pkg::RSP_BITS-1:0]     rsp_col_margin,
   output logic [twtc_pkg::RSP_BITS-1:0]     rsp_slice_total,
   output logic [twtc_pkg::RSP_BITS-1:0]     rsp_complete_total,
   input  logic                              csr_wr_en,
   input  logic [1:0]                        csr_index,
   input  logic [twtc_pkg::LCOUNT_BITS-1:0]  csr_wdata
);
   import twtc_pkg::*;

   localparam int unsigned Z_AW       = (MAX_Z_LEVELS > 1) ? $clog2(MAX_Z_LEVELS) : 1;
   localparam int unsigned ROW_DEPTH  = MAX_Z_LEVELS * MAX_X_LEVELS;
   localparam int unsigned COL_DEPTH  = MAX_Z_LEVELS * MAX_Y_LEVELS;
   localparam int unsigned CELL_DEPTH = ROW_DEPTH * MAX_Y_LEVELS;
   localparam int unsigned ROW_AW     = $clog2(ROW_DEPTH);
   localparam int unsigned COL_AW     = $clog2(COL_DEPTH);
   localparam int unsigned CELL_AW    = $clog2(CELL_DEPTH);

   twtc_state_type state_ff, state_in;

   logic [LCOUNT_BITS-1:0] x_count_ff, y_count_ff, z_count_ff;
   logic [COUNT_BITS-1:0]  total_ff, total_in;
   logic [CELL_AW-1:0]     sweep_ff, sweep_in;
   logic                   clear_rsp_ff, clear_rsp_in;

   twtc_dec_type         dec;
   twtc_dec_type         dec_ff;
   logic [CELL_AW-1:0]   cell_addr, cell_addr_ff;
   logic [ROW_AW-1:0]    row_addr, row_addr_ff;
   logic [COL_AW-1:0]    col_addr, col_addr_ff;
   logic [Z_AW-1:0]      slice_addr, slice_addr_ff;

   logic                 accept;
   logic                 rd_en;
   logic                 upd_we;
   logic                 sweep_on;
   logic                 sweep_last;

   logic [COUNT_BITS-1:0] cell_rd, row_rd, col_rd, slice_rd;
   logic [COUNT_BITS-1:0] cell_nx, row_nx, col_nx, slice_nx, total_nx;
   logic                  any_sat;

   logic [CELL_AW-1:0]    cell_wa;
   logic [ROW_AW-1:0]     row_wa;
   logic [COL_AW-1:0]     col_wa;
   logic [Z_AW-1:0]       slice_wa;
   logic                  row_we, col_we, slice_we;
   logic [COUNT_BITS-1:0] cell_wd, row_wd, col_wd, slice_wd;

   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [COUNT_BITS-1:0] rsp_cell_ff, rsp_cell_in;
   logic [COUNT_BITS-1:0] rsp_row_ff, rsp_row_in;
   logic [COUNT_BITS-1:0] rsp_col_ff, rsp_col_in;
   logic [COUNT_BITS-1:0] rsp_slice_ff, rsp_slice_in;
   logic [COUNT_BITS-1:0] rsp_total_ff, rsp_total_in;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   twtc_decode #(
      .MAX_X_LEVELS (MAX_X_LEVELS),
      .MAX_Y_LEVELS (MAX_Y_LEVELS),
      .Z_AW         (Z_AW),
      .ROW_AW       (ROW_AW),
      .COL_AW       (COL_AW),
      .CELL_AW      (CELL_AW)
   ) u_decode (
      .op          (req_op),
      .x_level     (req_x_level),
      .y_level     (req_y_level),
      .z_level     (req_z_level),
      .any_missing (req_x_missing | req_y_missing | req_z_missing),
      .x_count     (x_count_ff),
      .y_count     (y_count_ff),
      .z_count     (z_count_ff),
      .dec         (dec),
      .cell_addr   (cell_addr),
      .row_addr    (row_addr),
      .col_addr    (col_addr),
      .slice_addr  (slice_addr)
   );

   assign rd_en = accept && dec.hit;

   // level-count registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_count_ff <= clamp_levels(LEVEL_RESET, MAX_X_LEVELS);
         y_count_ff <= clamp_levels(LEVEL_RESET, MAX_Y_LEVELS);
         z_count_ff <= clamp_levels(LEVEL_RESET, MAX_Z_LEVELS);
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_X_LEVELS: x_count_ff <= clamp_levels(csr_wdata, MAX_X_LEVELS);
            REG_Y_LEVELS: y_count_ff <= clamp_levels(csr_wdata, MAX_Y_LEVELS);
            REG_Z_LEVELS: z_count_ff <= clamp_levels(csr_wdata, MAX_Z_LEVELS);
            default: begin
            end
         endcase
      end
   end

   // saturating update of the words read last cycle
   always_comb begin
      cell_nx  = (&cell_rd)  ? cell_rd  : cell_rd  + COUNT_BITS'(1);
      row_nx   = (&row_rd)   ? row_rd   : row_rd   + COUNT_BITS'(1);
      col_nx   = (&col_rd)   ? col_rd   : col_rd   + COUNT_BITS'(1);
      slice_nx = (&slice_rd) ? slice_rd : slice_rd + COUNT_BITS'(1);
      total_nx = (&total_ff) ? total_ff : total_ff + COUNT_BITS'(1);
      any_sat  = (&cell_rd) || (&row_rd) || (&col_rd) || (&slice_rd) || (&total_ff);
   end

   assign sweep_on   = (state_ff == ST_SWEEP);
   assign sweep_last = (32'(sweep_ff) == CELL_DEPTH - 1);
   assign upd_we     = (state_ff == ST_UPDATE) && dec_ff.hit && dec_ff.count;

   // write port: sweep zeroes, otherwise write back the update
   always_comb begin
      cell_wa  = sweep_on ? sweep_ff : cell_addr_ff;
      row_wa   = sweep_on ? sweep_ff[ROW_AW-1:0] : row_addr_ff;
      col_wa   = sweep_on ? sweep_ff[COL_AW-1:0] : col_addr_ff;
      slice_wa = sweep_on ? sweep_ff[Z_AW-1:0] : slice_addr_ff;
      row_we   = sweep_on ? (32'(sweep_ff) < ROW_DEPTH) : upd_we;
      col_we   = sweep_on ? (32'(sweep_ff) < COL_DEPTH) : upd_we;
      slice_we = sweep_on ? (32'(sweep_ff) < MAX_Z_LEVELS) : upd_we;
      cell_wd  = sweep_on ? '0 : cell_nx;
      row_wd   = sweep_on ? '0 : row_nx;
      col_wd   = sweep_on ? '0 : col_nx;
      slice_wd = sweep_on ? '0 : slice_nx;
   end

   twtc_ram #(.DEPTH(CELL_DEPTH), .WIDTH(COUNT_BITS), .ADDR_BITS(CELL_AW)) u_cells (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (cell_addr),
      .rd_data (cell_rd),
      .wr_en   (sweep_on || upd_we),
      .wr_addr (cell_wa),
      .wr_data (cell_wd)
   );

   twtc_ram #(.DEPTH(ROW_DEPTH), .WIDTH(COUNT_BITS), .ADDR_BITS(ROW_AW)) u_rows (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (row_addr),
      .rd_data (row_rd),
      .wr_en   (row_we),
      .wr_addr (row_wa),
      .wr_data (row_wd)
   );

   twtc_ram #(.DEPTH(COL_DEPTH), .WIDTH(COUNT_BITS), .ADDR_BITS(COL_AW)) u_cols (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (col_addr),
      .rd_data (col_rd),
      .wr_en   (col_we),
      .wr_addr (col_wa),
      .wr_data (col_wd)
   );

   twtc_ram #(.DEPTH(MAX_Z_LEVELS), .WIDTH(COUNT_BITS), .ADDR_BITS(Z_AW)) u_slices (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (slice_addr),
      .rd_data (slice_rd),
      .wr_en   (slice_we),
      .wr_addr (slice_wa),
      .wr_data (slice_wd)
   );

   // sequencer and result word
   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      clear_rsp_in  = clear_rsp_ff;
      total_in      = total_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = STATUS_DONE;
      rsp_cell_in   = '0;
      rsp_row_in    = '0;
      rsp_col_in    = '0;
      rsp_slice_in  = '0;
      rsp_total_in  = '0;
      case (state_ff)
         ST_SWEEP: begin
            sweep_in = sweep_ff + CELL_AW'(1);
            if (sweep_last) begin
               state_in      = ST_IDLE;
               clear_rsp_in  = 1'b0;
               rsp_strobe_in = clear_rsp_ff;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (dec.clear) begin
                  state_in     = ST_SWEEP;
                  sweep_in     = '0;
                  clear_rsp_in = 1'b1;
                  total_in     = '0;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_status_in = dec_ff.status;
            rsp_total_in  = total_ff;
            if (dec_ff.hit) begin
               if (dec_ff.count) begin
                  total_in      = total_nx;
                  rsp_status_in = any_sat ? STATUS_SAT : STATUS_DONE;
                  rsp_cell_in   = cell_nx;
                  rsp_row_in    = row_nx;
                  rsp_col_in    = col_nx;
                  rsp_slice_in  = slice_nx;
                  rsp_total_in  = total_nx;
               end else begin
                  rsp_cell_in   = cell_rd;
                  rsp_row_in    = row_rd;
                  rsp_col_in    = col_rd;
                  rsp_slice_in  = slice_rd;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_ff      <= '0;
         clear_rsp_ff  <= 1'b0;
         total_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         clear_rsp_ff  <= clear_rsp_in;
         total_ff      <= total_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dec_ff        <= dec;
         cell_addr_ff  <= cell_addr;
         row_addr_ff   <= row_addr;
         col_addr_ff   <= col_addr;
         slice_addr_ff <= slice_addr;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_slice_ff  <= rsp_slice_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_joint_count    = RSP_BITS'({{RSP_BITS{1'b0}}, rsp_cell_ff});
   assign rsp_row_margin     = RSP_BITS'({{RSP_BITS{1'b0}}, rsp_row_ff});
   assign rsp_col_margin     = RSP_BITS'({{RSP_BITS{1'b0}}, rsp_col_ff});
   assign rsp_slice_total    = RSP_BITS'({{RSP_BITS{1'b0}}, rsp_slice_ff});
   assign rsp_complete_total = RSP_BITS'({{RSP_BITS{1'b0}}, rsp_total_ff});

`ifndef SYNTH
   a_update_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> $past(accept))
      else $error("update cycle without an accepted word");

   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_UPDATE) || ($past(state_ff) == ST_SWEEP))
      else $error("result strobe outside update or sweep end");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !upd_we && !sweep_on)
      else $error("memory write while idle");

   a_reject_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == STATUS_MISSING || rsp_status == STATUS_RANGE))
      |-> (rsp_joint_count == '0) && (rsp_slice_total == '0))
      else $error("rejected word carries counts");
`endif

endmodule
